### rtl/asm_pkg.sv
// Package with the shared types and constants of the approximate substring matcher.
package asm_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65535;

   localparam int DIST_W  = $clog2(PATTERN_MAX + 1);
   localparam int TEXT_W  = 16;
   localparam int BEST_W  = 17;
   localparam int LEN_W   = 5;
   localparam int END_W   = 5;
   localparam int SYM_W   = 8;
   localparam int PIDX_W  = 4;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [PIDX_W-1:0] pattern_index;
      logic [SYM_W-1:0]  symbol;
      logic              last_text;
   } req_type;

   typedef struct packed {
      logic [END_W-1:0]  end_distance;
      logic [BEST_W-1:0] best_distance;
      logic [TEXT_W-1:0] best_position;
      logic              done_res;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [SYM_W-1:0]  sym;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] prev;
   } wave_type;

endpackage

### rtl/asm_cell.sv
// One pattern row of the systolic chain: pattern symbol, column entry and the update step.
module asm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [asm_pkg::DIST_W-1:0]  row_number,
   input  logic                        load_en,
   input  logic [asm_pkg::SYM_W-1:0]   load_sym,
   input  asm_pkg::wave_type           wave_in,
   output asm_pkg::wave_type           wave_out
);
   import asm_pkg::*;

   logic [SYM_W-1:0]  pat_ff;
   logic [SYM_W-1:0]  pat_in;
   logic [DIST_W-1:0] dp_ff;
   logic [DIST_W-1:0] dp_in;
   wave_type          wave_ff;
   wave_type          wave_in_next;
   logic [DIST_W:0]   old_inc;
   logic [DIST_W:0]   prev_inc;
   logic [DIST_W:0]   diag_inc;
   logic [DIST_W:0]   best;
   logic [DIST_W-1:0] value;

   always_comb begin
      old_inc  = {1'b0, dp_ff} + 1'b1;
      prev_inc = {1'b0, wave_in.prev} + 1'b1;
      diag_inc = {1'b0, wave_in.diag} + 1'b1;
      best     = old_inc;
      if (prev_inc < best) begin
         best = prev_inc;
      end
      if (diag_inc < best) begin
         best = diag_inc;
      end
      if (pat_ff == wave_in.sym) begin
         value = wave_in.diag;
      end else begin
         value = best[DIST_W-1:0];
      end
   end

   always_comb begin
      pat_in = load_en ? load_sym : pat_ff;
      dp_in  = dp_ff;
      if (clear) begin
         dp_in = row_number;
      end else if (wave_in.valid) begin
         dp_in = value;
      end
      wave_in_next.valid = wave_in.valid;
      wave_in_next.sym   = wave_in.sym;
      wave_in_next.diag  = dp_ff;
      wave_in_next.prev  = value;
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff         <= row_number;
         wave_ff.valid <= 1'b0;
      end else begin
         dp_ff         <= dp_in;
         wave_ff.valid <= wave_in_next.valid;
      end
      wave_ff.sym  <= wave_in_next.sym;
      wave_ff.diag <= wave_in_next.diag;
      wave_ff.prev <= wave_in_next.prev;
   end

   assign wave_out = wave_ff;

endmodule

### rtl/approximate_substring_match.sv
// Top level of the approximate substring matcher: cell chain, result tracking and ports.
// A text transaction passes one cell per cycle up to the pattern length; the end distance
// is then registered, and the result is registered once the receiver does not stall. The
// next transaction is taken only after the result is registered. Pattern loads wait as well.
// Synchronous reset clears the column to row numbers, the counters, the minimum and the
// pattern length (to 1); pattern symbols stay undefined until written.
module approximate_substring_match (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  asm_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output asm_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [asm_pkg::LEN_W-1:0]  csr_data
);
   import asm_pkg::*;

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [DIST_W-1:0]  used_len;
   logic               busy_ff;
   logic               busy_in;
   logic               last_ff;
   logic               last_in;
   logic               pend_ff;
   logic               pend_in;
   logic [DIST_W-1:0]  end_ff;
   logic [DIST_W-1:0]  end_in;
   wave_type           wave0_ff;
   wave_type           wave0_in;
   logic [TEXT_W-1:0]  count_ff;
   logic [TEXT_W-1:0]  count_in;
   logic [BEST_W-1:0]  min_ff;
   logic [BEST_W-1:0]  min_in;
   logic [TEXT_W-1:0]  pos_ff;
   logic [TEXT_W-1:0]  pos_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   logic               text_accept;
   logic               load_out;
   logic               wave_done;
   logic               clear;
   logic [TEXT_W-1:0]  count_next;
   logic [BEST_W-1:0]  min_next;
   logic [TEXT_W-1:0]  pos_next;
   logic [BEST_W-1:0]  count_plus;
   logic [BEST_W-1:0]  end_ext;
   logic [DIST_W+END_W-1:0] end_wide;

   wave_type           cell_in  [PATTERN_MAX];
   wave_type           cell_out [PATTERN_MAX];
   logic               stop     [PATTERN_MAX];
   logic               load_en  [PATTERN_MAX];

   assign accept      = req_valid & ~req_stall;
   assign text_accept = accept & (req_data.kind == KIND_TEXT);
   assign req_stall   = busy_ff;
   assign csr_ready   = 1'b1;
   assign load_out    = pend_ff & (~rsp_valid_ff | ~rsp_stall);
   assign clear       = load_out & last_ff;

   always_comb begin
      int m;
      m = int'(len_ff);
      if (m < 1) begin
         m = 1;
      end
      if (m > PATTERN_MAX) begin
         m = PATTERN_MAX;
      end
      used_len = DIST_W'(m);
   end

   always_comb begin
      wave0_in.valid = text_accept;
      wave0_in.sym   = req_data.symbol;
      wave0_in.diag  = '0;
      wave0_in.prev  = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         stop[i]    = (used_len == DIST_W'(i + 1));
         load_en[i] = accept & (req_data.kind == KIND_PATTERN)
                      & (32'(req_data.pattern_index) == i);
      end
      cell_in[0] = wave0_ff;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         cell_in[i]       = cell_out[i-1];
         cell_in[i].valid = cell_out[i-1].valid & ~stop[i-1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
         asm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (clear),
            .row_number (DIST_W'(g + 1)),
            .load_en    (load_en[g]),
            .load_sym   (req_data.symbol),
            .wave_in    (cell_in[g]),
            .wave_out   (cell_out[g])
         );
      end
   endgenerate

   always_comb begin
      wave_done = 1'b0;
      end_in    = end_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (cell_out[i].valid & stop[i]) begin
            wave_done = 1'b1;
            end_in    = cell_out[i].prev;
         end
      end
   end

   always_comb begin
      count_next = count_ff;
      if (32'(count_ff) < TEXT_MAX) begin
         count_next = count_ff + 1'b1;
      end
      end_ext  = BEST_W'(end_ff);
      min_next = min_ff;
      pos_next = pos_ff;
      if (end_ext < min_ff) begin
         min_next = end_ext;
         pos_next = count_next;
      end
      count_plus = {1'b0, count_next} + 1'b1;
      end_wide   = (DIST_W + END_W)'(end_ff);

      rsp_data_in.end_distance = (end_wide > (DIST_W + END_W)'(31)) ? END_W'(31)
                                                                    : end_wide[END_W-1:0];
      if (min_next < count_plus) begin
         rsp_data_in.best_distance = min_next;
         rsp_data_in.best_position = pos_next;
      end else begin
         rsp_data_in.best_distance = count_plus;
         rsp_data_in.best_position = '0;
      end
      rsp_data_in.done_res = last_ff;

      count_in = count_ff;
      min_in   = min_ff;
      pos_in   = pos_ff;
      if (load_out) begin
         if (last_ff) begin
            count_in = '0;
            min_in   = '1;
            pos_in   = '0;
         end else begin
            count_in = count_next;
            min_in   = min_next;
            pos_in   = pos_next;
         end
      end
   end

   always_comb begin
      len_in  = (csr_valid & csr_ready) ? csr_data : len_ff;
      last_in = text_accept ? req_data.last_text : last_ff;
      busy_in = busy_ff;
      if (text_accept) begin
         busy_in = 1'b1;
      end else if (load_out) begin
         busy_in = 1'b0;
      end
      pend_in = pend_ff;
      if (wave_done) begin
         pend_in = 1'b1;
      end else if (load_out) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= LEN_W'(1);
         busy_ff        <= 1'b0;
         pend_ff        <= 1'b0;
         wave0_ff.valid <= 1'b0;
         count_ff       <= '0;
         min_ff         <= '1;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         len_ff         <= len_in;
         busy_ff        <= busy_in;
         pend_ff        <= pend_in;
         wave0_ff.valid <= wave0_in.valid;
         count_ff       <= count_in;
         min_ff         <= min_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      wave0_ff.sym  <= wave0_in.sym;
      wave0_ff.diag <= wave0_in.diag;
      wave0_ff.prev <= wave0_in.prev;
      last_ff       <= last_in;
      end_ff        <= end_in;
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### verif/asm_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the matcher's distance results and compares them on the result channel.
module asm_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  asm_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  asm_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [asm_pkg::LEN_W-1:0] csr_data,
   output int                        error_count,
   output int                        pending,
   output int                        checked_count,
   output int                        search_count
);
   import asm_pkg::*;

   localparam int PRINT_LIMIT = 40;

   logic [SYM_W-1:0] pattern_sym [PATTERN_MAX];
   int unsigned      column [PATTERN_MAX+1];
   int unsigned      text_seen;
   int unsigned      low_distance;
   int unsigned      low_position;
   logic [LEN_W-1:0] length_reg;
   rsp_type          expected_scores [$];
   int               fails = 0;
   int               results = 0;
   int               searches = 0;

   task automatic report_mismatch(input string what);
      if (fails < PRINT_LIMIT) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      fails++;
   endtask

   task automatic check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic clear_search();
      int r;
      for (r = 0; r <= PATTERN_MAX; r++) begin
         column[r] = r;
      end
      text_seen = 0;
      low_distance = 32'h1FFFF;
      low_position = 0;
   endtask

   task automatic score_text_symbol(input req_type item);
      int unsigned rows;
      int unsigned diag;
      int unsigned up;
      int unsigned old;
      int unsigned entry;
      int unsigned best_d;
      int unsigned best_p;
      int          r;
      rsp_type     score;
      if (length_reg == 0) begin
         rows = 1;
      end else if (length_reg > PATTERN_MAX) begin
         rows = PATTERN_MAX;
      end else begin
         rows = length_reg;
      end
      diag = 0;
      up = 0;
      for (r = 1; r <= rows; r++) begin
         old = column[r];
         if (pattern_sym[r-1] == item.symbol) begin
            entry = diag;
         end else begin
            entry = old + 1;
            if (up + 1 < entry) entry = up + 1;
            if (diag + 1 < entry) entry = diag + 1;
         end
         column[r] = entry;
         diag = old;
         up = entry;
      end
      if (text_seen < TEXT_MAX) text_seen++;
      if (column[rows] < low_distance) begin
         low_distance = column[rows];
         low_position = text_seen;
      end
      if (low_distance < text_seen + 1) begin
         best_d = low_distance;
         best_p = low_position;
      end else begin
         best_d = text_seen + 1;
         best_p = 0;
      end
      score.end_distance  = (column[rows] > 31) ? 5'd31 : column[rows][END_W-1:0];
      score.best_distance = best_d[BEST_W-1:0];
      score.best_position = best_p[TEXT_W-1:0];
      score.done_res      = item.last_text;
      expected_scores.push_back(score);
      if (item.last_text) begin
         searches++;
         clear_search();
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_search();
         length_reg = 1;
         expected_scores.delete();
      end else begin
         if (csr_valid && csr_ready) length_reg = csr_data;
         if (req_valid && !req_stall) begin
            if (req_data.kind == KIND_PATTERN) begin
               pattern_sym[req_data.pattern_index] = req_data.symbol;
            end else begin
               score_text_symbol(req_data);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               report_mismatch($sformatf("result with end_distance %0d and no text pending",
                                         rsp_data.end_distance));
            end else begin
               want = expected_scores.pop_front();
               check_field("end_distance", rsp_data.end_distance, want.end_distance);
               check_field("best_distance", rsp_data.best_distance, want.best_distance);
               check_field("best_position", rsp_data.best_position, want.best_position);
               check_field("done_res", rsp_data.done_res, want.done_res);
               results++;
            end
         end
      end
      error_count   <= fails;
      pending       <= expected_scores.size();
      checked_count <= results;
      search_count  <= searches;
   end

endmodule

### verif/tb_approximate_substring_match.sv
`timescale 1ns / 1ps
// Testbench top for the approximate substring matcher: clock, reset, stimulus and verdict.
module tb_approximate_substring_match;
   import asm_pkg::*;

   localparam int DRAIN_CYCLES = PATTERN_MAX + 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int ITEM_TARGET  = 1500;
   localparam int LONG_TEXT    = 40;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data;
   int               error_count;
   int               pending;
   int               checked_count;
   int               search_count;
   logic [SYM_W-1:0] loaded [PATTERN_MAX];
   bit               calm = 1'b0;
   int               holds_wanted = 0;
   int               holds_done = 0;
   int               items_sent = 0;
   int               settings_used = 0;
   int               quiet_cycles = 0;

   always #2 clock = ~clock;

   approximate_substring_match dut (.*);

   asm_checker u_checker (.*);

   task automatic send(input req_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic load_symbol(input logic [PIDX_W-1:0] index, input logic [SYM_W-1:0] value,
                              input logic mark);
      req_type item;
      item.kind          = KIND_PATTERN;
      item.pattern_index = index;
      item.symbol        = value;
      item.last_text     = mark;
      loaded[index] = value;
      send(item);
   endtask

   function automatic req_type text_item(input logic [SYM_W-1:0] value, input logic mark);
      req_type item;
      item.kind          = KIND_TEXT;
      item.pattern_index = PIDX_W'($urandom_range(0, PATTERN_MAX - 1));
      item.symbol        = value;
      item.last_text     = mark;
      return item;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [LEN_W-1:0] choose_length();
      case ($urandom_range(0, 7))
         0: return LEN_W'(0);
         1: return LEN_W'(1);
         2: return LEN_W'(PATTERN_MAX);
         3: return LEN_W'(31);
         4: return LEN_W'($urandom_range(PATTERN_MAX + 1, 31));
         default: return LEN_W'($urandom_range(1, PATTERN_MAX));
      endcase
   endfunction

   // Text mostly follows the loaded pattern so that close matches show up.
   task automatic run_search(input int count, input bit close);
      int               cursor;
      int               pick;
      int               k;
      logic [SYM_W-1:0] value;
      cursor = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, PATTERN_MAX - 1);
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            value = loaded[cursor];
            cursor = (cursor + 1) % PATTERN_MAX;
         end else if (pick < 8) begin
            value = SYM_W'($urandom_range(0, 255));
         end else begin
            cursor = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, PATTERN_MAX - 1);
            value = loaded[cursor];
         end
         send(text_item(value, close && (k == count - 1)));
      end
   endtask

   initial begin : receiver
      int wait_cycles;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_done < holds_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         wait_cycles = calm ? 0 : $urandom_range(0, 5);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("No transaction for %0d cycles.", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      int phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The last mark on the final pattern load must be ignored.
      for (i = 0; i < PATTERN_MAX; i++) begin
         load_symbol(PIDX_W'(i),
                     (i == 0) ? 8'h00 : (i == PATTERN_MAX - 1) ? 8'hFF : SYM_W'(8'h40 + i),
                     i == PATTERN_MAX - 1);
      end
      write_length(LEN_W'(4));
      send(text_item(8'h00, 1'b0));
      send(text_item(8'h41, 1'b0));
      send(text_item(8'h42, 1'b0));
      send(text_item(8'h43, 1'b0));
      send(text_item(8'hFF, 1'b0));
      send(text_item(8'h41, 1'b1));
      write_length(LEN_W'(0));
      send(text_item(8'h00, 1'b1));
      write_length(LEN_W'(31));
      send(text_item(8'hFF, 1'b0));
      send(text_item(8'h00, 1'b0));
      // Shortening the pattern in the middle of a search.
      write_length(LEN_W'(2));
      send(text_item(8'h41, 1'b1));

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 2) != 0) write_length(choose_length());
         repeat ($urandom_range(0, 4)) begin
            load_symbol(PIDX_W'($urandom_range(0, PATTERN_MAX - 1)),
                        SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         if (phase == 2) holds_wanted++;
         repeat ($urandom_range(1, 4)) begin
            run_search($urandom_range(1, 24), $urandom_range(0, 7) != 0);
         end
         phase++;
      end

      // One longer text against a single-symbol pattern without pacing gaps.
      calm = 1'b1;
      write_length(LEN_W'(1));
      run_search(LONG_TEXT, 1'b1);

      wait_idle();
      $display("Checked %0d results over %0d searches and %0d length settings,",
               checked_count, search_count, settings_used);
      $display("with random pacing, a long receiver hold and a %0d-symbol text.", LONG_TEXT);
      if (error_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/asm_pkg.sv
rtl/asm_cell.sv
rtl/approximate_substring_match.sv
verif/asm_checker.sv
verif/tb_approximate_substring_match.sv
